>>> rtl/core/egm_pkg.sv
// Shared definitions for the extrema gossip merge core.
// Holds default widths, the register reset value, the operation codes and
// the flag bundle passed from the merge logic to the output stage.
package egm_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int TTL_WIDTH_DEF   = 16;
    localparam int MAX_TTL_RESET   = 16;

    typedef enum logic
    {
        OP_MERGE = 1'b0,
        OP_AGE   = 1'b1
    } egm_op_t;

    typedef struct packed
    {
        logic changed;
        logic last;
    } egm_flags_t;

endpackage

>>> rtl/core/egm_merge_logic.sv
// Combinational merge/age rules for one vector element.
// Depends on egm_pkg for the operation codes and the flag bundle.
module egm_merge_logic #(
    parameter int VALUE_WIDTH = 32,
    parameter int TTL_WIDTH   = 16
) (
    input  egm_pkg::egm_op_t            op,
    input  logic signed [VALUE_WIDTH-1:0] own_value,
    input  logic signed [TTL_WIDTH-1:0]   own_ttl,
    input  logic [VALUE_WIDTH-2:0]        own_origin,
    input  logic signed [VALUE_WIDTH-1:0] peer_value,
    input  logic signed [TTL_WIDTH-1:0]   peer_ttl,
    input  logic [VALUE_WIDTH-2:0]        peer_origin,
    input  logic                          last_element,
    input  logic [TTL_WIDTH-2:0]          max_ttl,
    output logic signed [VALUE_WIDTH-1:0] own_value_out,
    output logic [TTL_WIDTH-2:0]          own_ttl_out,
    output logic signed [VALUE_WIDTH-1:0] peer_value_out,
    output logic [TTL_WIDTH-2:0]          peer_ttl_out,
    output egm_pkg::egm_flags_t           flags
);
    import egm_pkg::*;

    localparam int TO = TTL_WIDTH - 1;
    localparam int TX = TTL_WIDTH + 1;

    // saturate a widened signed TTL into the unsigned result range
    function automatic logic [TO-1:0] ttl_clip(input logic signed [TX-1:0] x);
        logic [TO-1:0] r;
        begin
            if (x[TX-1])
                r = '0;
            else if (x[TX-2])
                r = '1;
            else
                r = x[TO-1:0];
            return r;
        end
    endfunction

    logic signed [VALUE_WIDTH-1:0] org1, org2, v1, v2;
    logic signed [TTL_WIDTH-1:0]   t1, t2, mt_s;
    logic signed [TX-1:0]          t1x, t2x, mtx, aged;
    logic signed [VALUE_WIDTH:0]   seed_sum;
    logic                          exp1, exp2, pos1, pos2, neg1, neg2, seed_match;
    logic signed [VALUE_WIDTH-1:0] a1, a2;
    logic signed [TX-1:0]          ta1, ta2;
    logic                          ch;

    assign org1 = $signed({1'b0, own_origin});
    assign org2 = $signed({1'b0, peer_origin});
    assign mt_s = $signed({1'b0, max_ttl});
    assign mtx  = $signed({2'b00, max_ttl});

    // expired side reverts to its origin at max_ttl
    assign exp1 = own_ttl[TTL_WIDTH-1] || (own_ttl == '0);
    assign exp2 = peer_ttl[TTL_WIDTH-1] || (peer_ttl == '0);
    assign v1   = exp1 ? org1 : own_value;
    assign v2   = exp2 ? org2 : peer_value;
    assign t1   = exp1 ? mt_s : own_ttl;
    assign t2   = exp2 ? mt_s : peer_ttl;
    assign t1x  = $signed({t1[TTL_WIDTH-1], t1});
    assign t2x  = $signed({t2[TTL_WIDTH-1], t2});

    assign neg1 = v1[VALUE_WIDTH-1];
    assign neg2 = v2[VALUE_WIDTH-1];
    assign pos1 = !neg1 && (v1 != '0);
    assign pos2 = !neg2 && (v2 != '0);

    assign seed_sum   = $signed({v1[VALUE_WIDTH-1], v1}) + $signed({v2[VALUE_WIDTH-1], v2});
    assign seed_match = (seed_sum == '0);

    assign aged = $signed({own_ttl[TTL_WIDTH-1], own_ttl}) - TX'(1);

    always_comb
    begin
        a1 = '0;
        a2 = '0;
        ta1 = '0;
        ta2 = '0;
        ch = 1'b0;
        case (op)
            OP_AGE:
            begin
                a1 = own_value;
                if (own_value == org1)
                    ta1 = mtx;
                else if (aged[TX-1] || (aged == '0))
                begin
                    a1 = org1;
                    ta1 = mtx;
                end
                else
                    ta1 = aged;
            end
            OP_MERGE:
            begin
                ch = (exp1 && (own_value != org1)) || (exp2 && (peer_value != org2))
                     || (v1 != v2) || neg1;
                if (pos1 && pos2)
                begin
                    if (v1 > v2)
                    begin
                        a1 = v2; ta1 = t2x - TX'(1); a2 = v2; ta2 = t2x;
                    end
                    else if (v1 < v2)
                    begin
                        a1 = v1; ta1 = t1x; a2 = v1; ta2 = t1x - TX'(1);
                    end
                    else if (t1 < t2)
                    begin
                        a1 = v1; ta1 = t2x - TX'(1); a2 = v1; ta2 = t2x;
                    end
                    else if (t1 > t2)
                    begin
                        a1 = v1; ta1 = t1x; a2 = v1; ta2 = t1x - TX'(1);
                    end
                    else
                    begin
                        a1 = v1; ta1 = t1x; a2 = v1; ta2 = t2x;
                    end
                end
                else if (neg1 && pos2)
                begin
                    a1 = v1; a2 = v1;
                    ta1 = seed_match ? mtx : (t1x >>> 1);
                    ta2 = ta1;
                end
                else if (pos1 && neg2)
                begin
                    a1 = v2; a2 = v2;
                    ta1 = seed_match ? mtx : (t2x >>> 1);
                    ta2 = ta1;
                end
                else if (v1 == v2)
                begin
                    a1 = v1; ta1 = t1x >>> 1;
                    a2 = v2; ta2 = t2x >>> 1;
                end
                else if (v1 < v2)
                begin
                    a1 = v1; a2 = v1;
                    ta1 = t1x >>> 1; ta2 = ta1;
                end
                else
                begin
                    a1 = v2; a2 = v2;
                    ta1 = t2x >>> 1; ta2 = ta1;
                end
            end
            default:
            begin
                a1 = '0;
            end
        endcase
    end

    assign own_value_out  = a1;
    assign own_ttl_out    = ttl_clip(ta1);
    assign peer_value_out = a2;
    assign peer_ttl_out   = ttl_clip(ta2);
    assign flags.changed  = ch;
    assign flags.last     = last_element;

endmodule

>>> rtl/core/egm_out_stage.sv
// Result register and vector change accumulator.
// Depends on egm_pkg for the flag bundle from the merge logic.
module egm_out_stage #(
    parameter int VALUE_WIDTH = 32,
    parameter int TTL_WIDTH   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          advance,
    input  logic signed [VALUE_WIDTH-1:0] own_value_in,
    input  logic [TTL_WIDTH-2:0]          own_ttl_in,
    input  logic signed [VALUE_WIDTH-1:0] peer_value_in,
    input  logic [TTL_WIDTH-2:0]          peer_ttl_in,
    input  egm_pkg::egm_flags_t           flags_in,
    output logic                          out_valid,
    output logic signed [VALUE_WIDTH-1:0] own_value_out,
    output logic [TTL_WIDTH-2:0]          own_ttl_out,
    output logic signed [VALUE_WIDTH-1:0] peer_value_out,
    output logic [TTL_WIDTH-2:0]          peer_ttl_out,
    output logic                          element_changed,
    output logic                          vector_changed,
    output logic                          last_out
);
    import egm_pkg::*;

    logic                          valid_reg, valid_next;
    logic                          acc_reg, acc_next;
    logic                          vec_now;
    logic signed [VALUE_WIDTH-1:0] own_value_reg, peer_value_reg;
    logic [TTL_WIDTH-2:0]          own_ttl_reg, peer_ttl_reg;
    logic                          changed_reg, vec_reg, last_reg;

    assign vec_now = acc_reg | flags_in.changed;

    always_comb
    begin
        valid_next = valid_reg;
        acc_next = acc_reg;
        if (advance)
            valid_next = load;
        // clear the running OR once the last word of a vector is loaded
        if (load)
            acc_next = flags_in.last ? 1'b0 : vec_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            own_value_reg  <= own_value_in;
            own_ttl_reg    <= own_ttl_in;
            peer_value_reg <= peer_value_in;
            peer_ttl_reg   <= peer_ttl_in;
            changed_reg    <= flags_in.changed;
            vec_reg        <= vec_now;
            last_reg       <= flags_in.last;
        end
    end

    assign out_valid       = valid_reg;
    assign own_value_out   = own_value_reg;
    assign own_ttl_out     = own_ttl_reg;
    assign peer_value_out  = peer_value_reg;
    assign peer_ttl_out    = peer_ttl_reg;
    assign element_changed = changed_reg;
    assign vector_changed  = vec_reg;
    assign last_out        = last_reg;

endmodule

>>> rtl/core/extrema_gossip_merge_with_ttl_core.sv
// Top level of the extrema gossip merge core: input register, merge logic,
// result register. Depends on egm_pkg, egm_merge_logic and egm_out_stage.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata element pair, tuser op, tlast end
//  m_*       out  m_tvalid/m_tready  tdata new pair, tuser change flags, tlast
//  cfg_*     in   cfg_we             cfg_wdata = max_ttl
//
// One word per cycle unless m_tready stalls; m_tvalid is registered.
// The path is input register, merge/age compare-and-select, result register.
// m_tready low holds the result register and, once the input register is
// full too, drops s_tready. Reset clears valids, the change accumulator and
// sets max_ttl to its default.
module extrema_gossip_merge_with_ttl_core #(
    parameter int VALUE_WIDTH = egm_pkg::VALUE_WIDTH_DEF,
    parameter int TTL_WIDTH   = egm_pkg::TTL_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // own_value, own_ttl, own_origin, peer_value, peer_ttl, peer_origin, zero pad
    input  logic [((4*VALUE_WIDTH+2*TTL_WIDTH-2+7)/8)*8-1:0] s_tdata,
    input  logic                 s_tuser,  // operation
    input  logic                 s_tlast,  // last_element
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // own_value_out, own_ttl_out, peer_value_out, peer_ttl_out, zero pad
    output logic [((2*VALUE_WIDTH+2*TTL_WIDTH-2+7)/8)*8-1:0] m_tdata,
    output logic [1:0]           m_tuser,  // element_changed, vector_changed
    output logic                 m_tlast,  // last_out
    input  logic                 cfg_we,
    input  logic [TTL_WIDTH-2:0] cfg_wdata
);
    import egm_pkg::*;

    localparam int IN_W  = ((4*VALUE_WIDTH+2*TTL_WIDTH-2+7)/8)*8;
    localparam int OUT_W = ((2*VALUE_WIDTH+2*TTL_WIDTH-2+7)/8)*8;
    localparam int VW    = VALUE_WIDTH;
    localparam int TW    = TTL_WIDTH;

    logic                 in_valid_reg, in_valid_next;
    logic [IN_W-1:0]      in_data_reg;
    egm_op_t              op_reg;
    logic                 last_reg;
    logic [TW-2:0]        max_ttl_reg;
    logic                 advance, accept, load, out_valid;

    logic signed [VW-1:0] own_value, peer_value;
    logic signed [TW-1:0] own_ttl, peer_ttl;
    logic [VW-2:0]        own_origin, peer_origin;

    logic signed [VW-1:0] r_own_value, r_peer_value, o_own_value, o_peer_value;
    logic [TW-2:0]        r_own_ttl, r_peer_ttl, o_own_ttl, o_peer_ttl;
    egm_flags_t           r_flags;
    logic                 o_changed, o_vec, o_last;

    assign advance  = !out_valid || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign load     = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (load)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            max_ttl_reg  <= (TW-1)'(MAX_TTL_RESET);
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_we)
                max_ttl_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= s_tdata;
            op_reg      <= egm_op_t'(s_tuser);
            last_reg    <= s_tlast;
        end
    end

    assign own_value   = $signed(in_data_reg[VW-1:0]);
    assign own_ttl     = $signed(in_data_reg[VW +: TW]);
    assign own_origin  = in_data_reg[VW+TW +: VW-1];
    assign peer_value  = $signed(in_data_reg[2*VW+TW-1 +: VW]);
    assign peer_ttl    = $signed(in_data_reg[3*VW+TW-1 +: TW]);
    assign peer_origin = in_data_reg[3*VW+2*TW-1 +: VW-1];

    egm_merge_logic #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TTL_WIDTH   (TTL_WIDTH)
    ) u_merge (
        .op             (op_reg),
        .own_value      (own_value),
        .own_ttl        (own_ttl),
        .own_origin     (own_origin),
        .peer_value     (peer_value),
        .peer_ttl       (peer_ttl),
        .peer_origin    (peer_origin),
        .last_element   (last_reg),
        .max_ttl        (max_ttl_reg),
        .own_value_out  (r_own_value),
        .own_ttl_out    (r_own_ttl),
        .peer_value_out (r_peer_value),
        .peer_ttl_out   (r_peer_ttl),
        .flags          (r_flags)
    );

    egm_out_stage #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TTL_WIDTH   (TTL_WIDTH)
    ) u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (load),
        .advance         (advance),
        .own_value_in    (r_own_value),
        .own_ttl_in      (r_own_ttl),
        .peer_value_in   (r_peer_value),
        .peer_ttl_in     (r_peer_ttl),
        .flags_in        (r_flags),
        .out_valid       (out_valid),
        .own_value_out   (o_own_value),
        .own_ttl_out     (o_own_ttl),
        .peer_value_out  (o_peer_value),
        .peer_ttl_out    (o_peer_ttl),
        .element_changed (o_changed),
        .vector_changed  (o_vec),
        .last_out        (o_last)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = OUT_W'({o_peer_ttl, o_peer_value, o_own_ttl, o_own_value});
    assign m_tuser  = {o_vec, o_changed};
    assign m_tlast  = o_last;

endmodule
